// ----- src/tspcr_pkg.sv -----
`timescale 1ns / 1ps
package tspcr_pkg;

	localparam int PID_SLOTS_DEF = 128;
	localparam int PACKET_BYTES  = 188;
	localparam int LAST_POS      = PACKET_BYTES - 1;

	localparam logic [7:0] SYNC_BYTE = 8'h47;

	localparam int PID_W   = 13;
	localparam int BASE_W  = 33;
	localparam int EXT_W   = 9;
	localparam int TICK_W  = 42;
	localparam int CNT_W   = 32;
	localparam int RATE_W  = 32;

	// packet bits times ticks per second: 188 * 8 * 27e6
	localparam int K_W    = 36;
	localparam logic [K_W-1:0] RATE_K = 36'd40608000000;
	localparam int PROD_W = CNT_W + K_W;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [1:0]        afc;
		logic              len_nz;
		logic              disc;
		logic              pcr_flag;
		logic [BASE_W-1:0] base;
		logic [EXT_W-1:0]  ext;
	} hdr_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [TICK_W-1:0] clock;
		logic [CNT_W-1:0]  packet;
	} slot_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_TICKS,
		E_LOOK,
		E_CMP,
		E_GT,
		E_DIV,
		E_OUT
	} eng_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_DONE
	} md_state_t;

endpackage

// ----- src/ts_pcr_max_bitrate_meter.sv -----
`timescale 1ns / 1ps
// transport stream pcr bitrate meter: takes one stream byte per request on the
// slave side (restart in tuser clears everything before that byte), locks onto
// the first 0x47 and then cuts 188-byte packets; one result per packet leaves on
// the master side. bytes stream in at one per cycle; after the last byte of a
// packet the input stalls while the packet is processed and while its result
// waits for the output register: without a pcr the result is formed directly,
// otherwise the 27 mhz tick count is formed, the pid slots in the table memory
// are scanned, and for a rate a serial multiply is followed by a serial divide.
// the pid table is filled in order with a fill count, so it needs no clearing
// pass after reset or restart
module ts_pcr_max_bitrate_meter #(
	parameter int PID_SLOTS = tspcr_pkg::PID_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ts_byte
	input  logic        s_tuser,   // [0] restart
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] max_bitrate, [63:32] packet_number
	output logic [1:0]  m_tuser,   // [0] had_pcr, [1] pcr_dropped
	// tracking_enable register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import tspcr_pkg::*;

	logic              accept;
	logic              last;
	logic              busy;
	logic              enable_q;
	hdr_t              hdr;
	logic [RATE_W-1:0] rate;
	logic [CNT_W-1:0]  packet;
	logic              had_pcr;
	logic              dropped;

	// input waits only while a finished packet is processed and its result is handed to the output
	assign s_tready  = !busy;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// tracking enable, reset to on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	// sync search, byte position and header field capture
	tspcr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.ts_byte (s_tdata),
		.restart (s_tuser),
		.hdr     (hdr),
		.last    (last)
	);

	// pid table, rate computation and result register
	tspcr_engine #(
		.PID_SLOTS (PID_SLOTS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (last),
		.restart     (accept && s_tuser),
		.hdr         (hdr),
		.enable      (enable_q),
		.busy        (busy),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_rate    (rate),
		.out_had_pcr (had_pcr),
		.out_dropped (dropped),
		.out_packet  (packet)
	);

	assign m_tdata = {packet, rate};
	assign m_tuser = {dropped, had_pcr};

endmodule

// ----- src/tspcr_parser.sv -----
`timescale 1ns / 1ps
module tspcr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           ts_byte,
	input  logic                 restart,
	output tspcr_pkg::hdr_t      hdr,
	output logic                 last
);
	import tspcr_pkg::*;

	logic       synced_q;
	logic [7:0] pos_q;
	hdr_t       hdr_q;
	logic       synced_now;
	logic       in_pkt;

	assign synced_now = restart ? 1'b0 : synced_q;
	assign in_pkt     = synced_now || (ts_byte == SYNC_BYTE);
	assign last       = accept && synced_now && (pos_q == 8'(LAST_POS));
	assign hdr        = hdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			pos_q    <= '0;
		end else if (accept) begin
			if (!synced_now) begin
				synced_q <= in_pkt;
				pos_q    <= in_pkt ? 8'd1 : 8'd0;
			end else begin
				synced_q <= 1'b1;
				pos_q    <= (pos_q == 8'(LAST_POS)) ? 8'd0 : pos_q + 8'd1;
			end
		end
	end

	// header fields captured one byte at a time
	always_ff @(posedge clk) begin
		if (accept && synced_now) begin
			unique case (pos_q)
				8'd1: hdr_q.pid[12:8] <= ts_byte[4:0];
				8'd2: hdr_q.pid[7:0] <= ts_byte;
				8'd3: hdr_q.afc <= ts_byte[5:4];
				8'd4: hdr_q.len_nz <= (ts_byte != 8'd0);
				8'd5: begin
					hdr_q.disc     <= ts_byte[7];
					hdr_q.pcr_flag <= ts_byte[4];
				end
				8'd6: hdr_q.base[32:25] <= ts_byte;
				8'd7: hdr_q.base[24:17] <= ts_byte;
				8'd8: hdr_q.base[16:9] <= ts_byte;
				8'd9: hdr_q.base[8:1] <= ts_byte;
				8'd10: begin
					hdr_q.base[0] <= ts_byte[7];
					hdr_q.ext[8]  <= ts_byte[0];
				end
				8'd11: hdr_q.ext[7:0] <= ts_byte;
				default: ;
			endcase
		end
	end

endmodule

// ----- src/tspcr_muldiv.sv -----
`timescale 1ns / 1ps
module tspcr_muldiv (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [tspcr_pkg::CNT_W-1:0]            n,
	input  logic [tspcr_pkg::TICK_W-1:0]           d,
	output logic                                   done,
	output logic [tspcr_pkg::RATE_W-1:0]           rate
);
	import tspcr_pkg::*;

	md_state_t         state_q, state_d;
	logic [6:0]        cnt_q;
	logic [CNT_W-1:0]  n_q;
	logic [TICK_W-1:0] d_q;
	logic [PROD_W-1:0] prod_q;
	logic [TICK_W-1:0] r_q;
	logic [RATE_W-1:0] q_q;
	logic              ovf_q;
	logic [TICK_W:0]   r_sh;
	logic              ge;

	assign r_sh = {r_q, prod_q[PROD_W-1]};
	assign ge   = (r_sh >= {1'b0, d_q});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MD_IDLE: if (start) state_d = MD_MUL;
			MD_MUL:  if (cnt_q == 7'd0) state_d = MD_DIV;
			MD_DIV:  if (cnt_q == 7'd0) state_d = MD_DONE;
			MD_DONE: state_d = MD_IDLE;
			default: state_d = MD_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == MD_DONE);
		rate = ovf_q ? '1 : q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				MD_IDLE: cnt_q <= 7'(CNT_W - 1);
				MD_MUL:  cnt_q <= (cnt_q == 7'd0) ? 7'(PROD_W - 1) : cnt_q - 7'd1;
				MD_DIV:  cnt_q <= cnt_q - 7'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			MD_IDLE: begin
				n_q    <= n;
				d_q    <= d;
				prod_q <= '0;
				r_q    <= '0;
				q_q    <= '0;
				ovf_q  <= 1'b0;
			end
			MD_MUL: begin
				// shift-add, one multiplier bit per cycle, msb first
				prod_q <= {prod_q[PROD_W-2:0], 1'b0}
					+ (n_q[CNT_W-1] ? PROD_W'(RATE_K) : '0);
				n_q    <= {n_q[CNT_W-2:0], 1'b0};
			end
			MD_DIV: begin
				// restoring division, one quotient bit per cycle
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				r_q    <= ge ? TICK_W'(r_sh - {1'b0, d_q}) : r_sh[TICK_W-1:0];
				q_q    <= {q_q[RATE_W-2:0], ge};
				ovf_q  <= ovf_q | q_q[RATE_W-1];
			end
			default: ;
		endcase
	end

endmodule

// ----- src/tspcr_engine.sv -----
`timescale 1ns / 1ps
module tspcr_engine #(
	parameter int PID_SLOTS = tspcr_pkg::PID_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             restart,
	input  tspcr_pkg::hdr_t                  hdr,
	input  logic                             enable,
	output logic                             busy,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tspcr_pkg::RATE_W-1:0]     out_rate,
	output logic                             out_had_pcr,
	output logic                             out_dropped,
	output logic [tspcr_pkg::CNT_W-1:0]      out_packet
);
	import tspcr_pkg::*;

	localparam int CW = $clog2(PID_SLOTS + 1);
	localparam int AW = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;

	eng_state_t        state_q, state_d;
	hdr_t              hdr_q;
	logic [TICK_W-1:0] ticks_q;
	logic [1:0]        step_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     fill_q;
	logic [RATE_W-1:0] best_q;
	logic [CNT_W-1:0]  pkt_q;
	logic              drop_q;
	logic              has_q;
	logic              ov_q;
	logic [RATE_W-1:0] o_rate_q;
	logic              o_pcr_q;
	logic              o_drop_q;
	logic [CNT_W-1:0]  o_pkt_q;

	slot_t             slot_mem_q [PID_SLOTS];
	slot_t             rd_q;
	slot_t             wdata;
	logic              we;
	logic              re;
	logic [AW-1:0]     addr;

	logic              has_now;
	logic              at_end;
	logic              full;
	logic              hit;
	logic              later;
	logic [TICK_W-1:0] term;
	logic              md_start;
	logic              md_done;
	logic [RATE_W-1:0] md_rate;
	logic              out_free;

	assign has_now  = hdr.afc[1] && hdr.len_nz && hdr.pcr_flag;
	assign at_end   = (idx_q == fill_q);
	assign full     = (fill_q == CW'(PID_SLOTS));
	assign hit      = (rd_q.pid == hdr_q.pid);
	assign later    = (ticks_q > rd_q.clock);
	assign addr     = idx_q[AW-1:0];
	assign out_free = !ov_q || out_ready;

	always_comb begin
		unique case (step_q)
			2'd0: term = TICK_W'({hdr_q.base, 8'd0});
			2'd1: term = TICK_W'({hdr_q.base, 5'd0});
			2'd2: term = TICK_W'({hdr_q.base, 3'd0});
			default: term = TICK_W'({hdr_q.base, 2'd0});
		endcase
	end

	tspcr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.n      (pkt_q - rd_q.packet),
		.d      (ticks_q - rd_q.clock),
		.done   (md_done),
		.rate   (md_rate)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE:  if (start) state_d = has_now ? E_TICKS : E_OUT;
			E_TICKS: if (step_q == 2'd3) state_d = E_LOOK;
			E_LOOK:  state_d = at_end ? E_OUT : E_CMP;
			E_CMP: begin
				if (hit) state_d = hdr_q.disc ? E_OUT : E_GT;
				else     state_d = E_LOOK;
			end
			E_GT:    state_d = later ? E_DIV : E_OUT;
			E_DIV:   if (md_done) state_d = E_OUT;
			E_OUT:   if (out_free) state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q != E_IDLE);
		re       = (state_q == E_LOOK) && !at_end;
		we       = 1'b0;
		md_start = 1'b0;
		wdata    = '{pid: hdr_q.pid, clock: ticks_q, packet: pkt_q};
		unique case (state_q)
			E_LOOK: we = at_end && !full;
			E_CMP: begin
				we          = hit && hdr_q.disc;
				wdata.clock = rd_q.clock;
			end
			E_GT: begin
				we           = !later;
				md_start     = later;
				wdata.packet = rd_q.packet;
			end
			E_DIV: we = md_done;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) slot_mem_q[addr] <= wdata;
		if (re) rd_q <= slot_mem_q[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			fill_q  <= '0;
			best_q  <= '0;
			pkt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				fill_q <= '0;
				best_q <= '0;
				pkt_q  <= '0;
			end
			if (state_q == E_IDLE && start) pkt_q <= pkt_q + 1'b1;
			if (state_q == E_LOOK && at_end && !full) fill_q <= fill_q + 1'b1;
			if (state_q == E_DIV && md_done && md_rate > best_q) best_q <= md_rate;
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (state_q == E_OUT && out_free) ov_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				hdr_q   <= hdr;
				has_q   <= has_now;
				drop_q  <= 1'b0;
				step_q  <= '0;
				idx_q   <= '0;
				ticks_q <= TICK_W'(hdr.ext);
			end
			E_TICKS: begin
				ticks_q <= ticks_q + term;
				step_q  <= step_q + 2'd1;
			end
			E_LOOK: drop_q <= at_end && full;
			E_CMP: if (!hit) idx_q <= idx_q + 1'b1;
			E_OUT: begin
				if (out_free) begin
					o_rate_q <= enable ? best_q : '0;
					o_pcr_q  <= has_q;
					o_drop_q <= drop_q;
					o_pkt_q  <= pkt_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = ov_q;
	assign out_rate    = o_rate_q;
	assign out_had_pcr = o_pcr_q;
	assign out_dropped = o_drop_q;
	assign out_packet  = o_pkt_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(PID_SLOTS))
		else $error("slot fill count beyond table size");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == E_IDLE)
		else $error("packet end while engine busy");
	a_restart_clr: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> fill_q == '0 && best_q == '0)
		else $error("restart did not clear table and maximum");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_OUT && !ov_q) |=> (state_q == E_IDLE && ov_q))
		else $error("result not loaded into free output register");
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_OUT && drop_q) |-> full)
		else $error("pcr dropped with free slots");
`endif

endmodule
